[hdl/sorted_key_table_assert.svh]
// ----------------------------------------------------------------------------
// sorted_key_table_assert.svh
// Assertion macros for the sorted key table checks. Each macro samples on the
// rising edge of i_clk and is disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SKT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SKT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hdl/skt_pkg.sv]
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and codes for the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

    // fixed port widths
    localparam int OP_W       = 3;
    localparam int POS_W      = 4;
    localparam int KEY_PORT_W = 32;
    localparam int STATUS_W   = 2;
    localparam int IDX_W      = 5;
    localparam int PADDR_W    = 2;
    localparam int PDATA_W    = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_RM_POS = 3'd1;
    localparam logic [OP_W-1:0] OP_GET    = 3'd2;
    localparam logic [OP_W-1:0] OP_RM_VAL = 3'd3;
    localparam logic [OP_W-1:0] OP_SET    = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // register addresses
    localparam logic [PADDR_W-1:0] REG_COMPARE_SIGNED = 2'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_START,
        S_SCAN,
        S_SHIFT,
        S_PLACE,
        S_GET_RD,
        S_GET_DATA,
        S_FINISH
    } t_state;

endpackage

[hdl/sorted_key_table.sv]
// ----------------------------------------------------------------------------
// sorted_key_table
// Table of up to DEPTH keys kept in ascending order in a simple dual-port memory,
// with one key comparator and a shift engine run by a small sequencer.
// ----------------------------------------------------------------------------
// channel   direction  handshake                     word
// in        sink       i_in_valid / o_in_ready       i_op, i_position, i_key
// out       source     o_out_valid / i_out_ready     o_status, o_index,
//                                                    o_read_key, o_count
// config    APB        psel, penable, pwrite, pready compare_signed at 0x0
//
// One word at a time; o_in_ready is high only while the sequencer is idle.
// Insert scans for its rank, shifts the entries above up and places the key;
// set removes the entry at position, then inserts as above; remove by value
// scans and shifts down, remove at position shifts down, get reads one entry,
// clear and rejected words finish; scan and shift each move one entry per cycle.
// The next word is taken while a finished result waits in the output register.
// Reset clears the entry count and the mode register; no memory clearing.
// ----------------------------------------------------------------------------
module sorted_key_table #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input word
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [skt_pkg::OP_W-1:0]         i_op,
    input  logic [skt_pkg::POS_W-1:0]        i_position,
    input  logic [skt_pkg::KEY_PORT_W-1:0]   i_key,
    // result word
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [skt_pkg::STATUS_W-1:0]     o_status,
    output logic [skt_pkg::IDX_W-1:0]        o_index,
    output logic [skt_pkg::KEY_PORT_W-1:0]   o_read_key,
    output logic [skt_pkg::IDX_W-1:0]        o_count,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [skt_pkg::PADDR_W-1:0]      paddr,
    input  logic [skt_pkg::PDATA_W-1:0]      pwdata,
    output logic [skt_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);
    import skt_pkg::*;

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int AW  = $clog2(DEPTH);
    localparam int XW  = (CW > POS_W) ? CW : POS_W;
    localparam int IW  = (CW > IDX_W) ? CW : IDX_W;
    localparam int KXW = (KEY_WIDTH > KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;

    function automatic logic f_key_less(input logic [KEY_WIDTH-1:0] a,
                                        input logic [KEY_WIDTH-1:0] b,
                                        input logic sgn);
        logic [KEY_WIDTH-1:0] x;
        logic [KEY_WIDTH-1:0] y;
        x = a;
        y = b;
        x[KEY_WIDTH-1] = a[KEY_WIDTH-1] ^ sgn;
        y[KEY_WIDTH-1] = b[KEY_WIDTH-1] ^ sgn;
        return x < y;
    endfunction

    logic [KEY_WIDTH-1:0] r_mem [DEPTH];
    logic [KEY_WIDTH-1:0] r_rdata;

    t_state                r_state, n_state;
    logic [OP_W-1:0]       r_op, n_op;
    logic [KEY_WIDTH-1:0]  r_key, n_key;
    logic [CW-1:0]         r_pos, n_pos;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_src, n_src;
    logic [CW-1:0]         r_left, n_left;
    logic [AW-1:0]         r_dst, n_dst;
    logic                  r_pend, n_pend;
    logic                  r_up, n_up;
    logic [CW-1:0]         r_ins_pos, n_ins_pos;
    logic [STATUS_W-1:0]   r_res_status, n_res_status;
    logic [CW-1:0]         r_res_idx, n_res_idx;
    logic [KEY_WIDTH-1:0]  r_res_key, n_res_key;
    logic                  r_cmp_signed;
    logic                  r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;
    logic [IDX_W-1:0]      r_out_index, n_out_index;
    logic [KEY_PORT_W-1:0] r_out_key, n_out_key;
    logic [IDX_W-1:0]      r_out_count, n_out_count;

    logic [KXW-1:0]        w_key_wide;
    logic [KEY_WIDTH-1:0]  w_key_in;
    logic [XW-1:0]         w_pos_x;
    logic [CW-1:0]         w_pos_c;
    logic                  w_pos_ok;
    logic                  w_full;
    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_mem_lt;
    logic                  w_eq;
    logic                  w_key_lt;
    logic                  w_at_end;
    logic [CW-1:0]         w_idx_inc;
    logic [AW-1:0]         w_rd_addr;
    logic                  w_mem_we;
    logic [AW-1:0]         w_mem_waddr;
    logic [KEY_WIDTH-1:0]  w_mem_wdata;
    logic [IW-1:0]         w_idx_ext;
    logic [IW-1:0]         w_cnt_ext;
    logic [KXW-1:0]        w_rkey_ext;
    logic                  w_cfg_we;

    assign w_key_wide = KXW'(i_key);
    assign w_key_in   = w_key_wide[KEY_WIDTH-1:0];
    assign w_pos_x    = XW'(i_position);
    assign w_pos_c    = w_pos_x[CW-1:0];
    assign w_pos_ok   = w_pos_x < XW'(r_count);
    assign w_full     = r_count == CW'(DEPTH);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_out_ready;

    // shared comparator on the word just read
    assign w_mem_lt  = f_key_less(r_rdata, r_key, r_cmp_signed);
    assign w_eq      = r_rdata == r_key;
    assign w_key_lt  = !w_mem_lt && !w_eq;
    assign w_at_end  = r_idx == r_count;
    assign w_idx_inc = r_idx + CW'(1);

    assign w_idx_ext  = IW'(r_res_idx);
    assign w_cnt_ext  = IW'(r_count);
    assign w_rkey_ext = KXW'(r_res_key);

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_index     = r_out_index;
    assign o_read_key  = r_out_key;
    assign o_count     = r_out_count;

    assign w_cfg_we = psel && penable && pwrite && (paddr == REG_COMPARE_SIGNED);
    assign prdata   = (paddr == REG_COMPARE_SIGNED) ? PDATA_W'(r_cmp_signed) : '0;
    assign pready   = 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_op)
                        OP_INSERT: n_state = w_full ? S_FINISH : S_SCAN_START;
                        OP_RM_POS,
                        OP_SET:    n_state = w_pos_ok ? S_SHIFT : S_FINISH;
                        OP_GET:    n_state = w_pos_ok ? S_GET_RD : S_FINISH;
                        OP_RM_VAL: n_state = S_SCAN_START;
                        default:   n_state = S_FINISH;
                    endcase
                end
            end
            S_SCAN_START: n_state = S_SCAN;
            S_SCAN: begin
                if (w_at_end) begin
                    n_state = (r_op == OP_RM_VAL) ? S_FINISH : S_SHIFT;
                end else if (r_op == OP_RM_VAL) begin
                    if (w_eq) begin
                        n_state = S_SHIFT;
                    end else if (w_key_lt) begin
                        n_state = S_FINISH;
                    end
                end else if (!w_mem_lt) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (r_left == '0) begin
                    if (r_up) begin
                        n_state = S_PLACE;
                    end else begin
                        n_state = (r_op == OP_SET) ? S_SCAN_START : S_FINISH;
                    end
                end
            end
            S_PLACE:    n_state = S_FINISH;
            S_GET_RD:   n_state = S_GET_DATA;
            S_GET_DATA: n_state = S_FINISH;
            S_FINISH:   if (w_out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_op         = r_op;
        n_key        = r_key;
        n_pos        = r_pos;
        n_count      = r_count;
        n_idx        = r_idx;
        n_src        = r_src;
        n_left       = r_left;
        n_dst        = r_dst;
        n_pend       = r_pend;
        n_up         = r_up;
        n_ins_pos    = r_ins_pos;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        n_res_key    = r_res_key;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_index  = r_out_index;
        n_out_key    = r_out_key;
        n_out_count  = r_out_count;
        w_rd_addr    = '0;
        w_mem_we     = 1'b0;
        w_mem_waddr  = '0;
        w_mem_wdata  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op         = i_op;
                    n_key        = w_key_in;
                    n_pos        = w_pos_c;
                    n_res_status = ST_OK;
                    n_res_idx    = '0;
                    n_res_key    = '0;
                    unique case (i_op)
                        OP_INSERT: if (w_full) n_res_status = ST_FULL;
                        OP_RM_POS,
                        OP_SET: begin
                            if (!w_pos_ok) begin
                                n_res_status = ST_RANGE;
                            end else begin
                                // close the gap above the removed entry
                                n_res_idx = w_pos_c;
                                n_src     = w_pos_c + CW'(1);
                                n_left    = r_count - w_pos_c - CW'(1);
                                n_up      = 1'b0;
                                n_pend    = 1'b0;
                            end
                        end
                        OP_GET: begin
                            if (!w_pos_ok) begin
                                n_res_status = ST_RANGE;
                            end else begin
                                n_res_idx = w_pos_c;
                            end
                        end
                        OP_CLEAR: n_count = '0;
                        default: ;
                    endcase
                end
            end
            S_SCAN_START: begin
                w_rd_addr = '0;
                n_idx     = '0;
            end
            S_SCAN: begin
                if (w_at_end) begin
                    if (r_op == OP_RM_VAL) begin
                        n_res_status = ST_NOT_FOUND;
                    end else begin
                        n_ins_pos = r_idx;
                        n_src     = r_count - CW'(1);
                        n_left    = '0;
                        n_up      = 1'b1;
                        n_pend    = 1'b0;
                    end
                end else if ((r_op == OP_RM_VAL) && w_eq) begin
                    n_res_idx = r_idx;
                    n_src     = w_idx_inc;
                    n_left    = r_count - w_idx_inc;
                    n_up      = 1'b0;
                    n_pend    = 1'b0;
                end else if ((r_op == OP_RM_VAL) && w_key_lt) begin
                    n_res_status = ST_NOT_FOUND;
                end else if ((r_op != OP_RM_VAL) && !w_mem_lt) begin
                    // open a slot at this rank
                    n_ins_pos = r_idx;
                    n_src     = r_count - CW'(1);
                    n_left    = r_count - r_idx;
                    n_up      = 1'b1;
                    n_pend    = 1'b0;
                end else begin
                    n_idx     = w_idx_inc;
                    w_rd_addr = (w_idx_inc == CW'(DEPTH)) ? '0 : w_idx_inc[AW-1:0];
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    w_mem_we    = 1'b1;
                    w_mem_waddr = r_dst;
                    w_mem_wdata = r_rdata;
                end
                if (r_left != '0) begin
                    w_rd_addr = r_src[AW-1:0];
                    n_pend    = 1'b1;
                    n_dst     = r_up ? r_src[AW-1:0] + AW'(1) : r_src[AW-1:0] - AW'(1);
                    n_src     = r_up ? r_src - CW'(1) : r_src + CW'(1);
                    n_left    = r_left - CW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_up) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            S_PLACE: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_ins_pos[AW-1:0];
                w_mem_wdata = r_key;
                n_count     = r_count + CW'(1);
                n_res_idx   = r_ins_pos;
            end
            S_GET_RD:   w_rd_addr = r_pos[AW-1:0];
            S_GET_DATA: n_res_key = r_rdata;
            S_FINISH: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_index  = w_idx_ext[IDX_W-1:0];
                    n_out_key    = w_rkey_ext[KEY_PORT_W-1:0];
                    n_out_count  = w_cnt_ext[IDX_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // key store
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_cmp_signed <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pend       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            if (w_cfg_we) begin
                r_cmp_signed <= pwdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_pos        <= n_pos;
        r_idx        <= n_idx;
        r_src        <= n_src;
        r_left       <= n_left;
        r_dst        <= n_dst;
        r_up         <= n_up;
        r_ins_pos    <= n_ins_pos;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        r_res_key    <= n_res_key;
        r_out_status <= n_out_status;
        r_out_index  <= n_out_index;
        r_out_key    <= n_out_key;
        r_out_count  <= n_out_count;
    end

endmodule

[hdl/skt_checker.sv]
// ----------------------------------------------------------------------------
// skt_checker
// Port-level checks for the sorted key table, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_key_table_assert.svh"

module skt_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic [skt_pkg::STATUS_W-1:0]     o_status,
    input logic [skt_pkg::IDX_W-1:0]        o_index,
    input logic [skt_pkg::KEY_PORT_W-1:0]   o_read_key,
    input logic [skt_pkg::IDX_W-1:0]        o_count
);
    import skt_pkg::*;

    // hold a stalled result word
    `SKT_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")
    `SKT_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_status) && $stable(o_index) && $stable(o_read_key) && $stable(o_count), "result changed while stalled")
    // a failed operation reports no position and no key
    `SKT_ASSERT_SAME(a_err_clean, o_out_valid && (o_status != ST_OK), (o_index == '0) && (o_read_key == '0), "error result carries data")
    // every word leaves the sequencer busy in the cycle after it is accepted
    `SKT_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "ready after accept")

endmodule

bind sorted_key_table skt_checker u_skt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_status    (o_status),
    .o_index     (o_index),
    .o_read_key  (o_read_key),
    .o_count     (o_count)
);
